// ----- src/cavd_pkg.sv -----
// Shared types and constants of the chunked stream deframer.
`timescale 1ns / 1ps
package cavd_pkg;

	localparam logic [7:0] PREFIX_BYTE = 8'h82;
	localparam logic [7:0] LEN_VIDEO = 8'd128;
	localparam logic [7:0] LEN_AUDIO_A = 8'd40;
	localparam logic [7:0] LEN_AUDIO_B = 8'd24;
	localparam logic [12:0] TS_SCALE = 13'd8000;
	localparam logic [15:0] BITRATE_RESET = 16'd6400;
	localparam int TS_BITS = 45;
	localparam int SIZE_BITS = 24;

	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_CLOSE = 2'd1;
	localparam logic [1:0] KIND_ERROR = 2'd2;

	localparam logic SEL_AUDIO = 1'b0;
	localparam logic SEL_VIDEO = 1'b1;

	// One request from the front to the back part.
	typedef struct packed {
		logic [1:0] kind;
		logic sel;
		logic [7:0] val;
		logic [3:0] seq;
		logic [SIZE_BITS-1:0] size;
		logic need_ts;
		logic [31:0] pos;
	} cavd_req_t;

endpackage

// ----- src/cavd_front.sv -----
// Byte parser: chunk framing, packet bookkeeping and request generation.
`timescale 1ns / 1ps
module cavd_front import cavd_pkg::*; #(
	parameter int LEN_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic in_fire,
	input logic [7:0] stream_byte,
	output logic req_valid,
	output cavd_req_t req
);

	typedef enum logic [2:0] {
		PH_WAIT, PH_HEADER, PH_EXPLEN, PH_VARLEN_FIRST, PH_VARLEN_MORE, PH_SKIP, PH_PAYLOAD
	} phase_t;

	localparam logic [LEN_BITS-1:0] LEN_MAX = '1;

	phase_t phase_q, n_phase;
	logic prefix_q, n_prefix;
	logic [2:0] type_q, n_type;
	logic [3:0] seq_q, n_seq;
	logic [LEN_BITS-1:0] rem_q, n_rem;
	logic [31:0] pos_q, n_pos;
	logic [1:0] open_q, n_open;
	logic [4:0] oseq_q [2];
	logic [4:0] n_oseq [2];
	logic [LEN_BITS-1:0] olen_q [2];
	logic [LEN_BITS-1:0] n_olen [2];
	logic halted_q, n_halted;

	logic hdr, begin_c, vl;
	logic [7:0] blen;
	logic [3:0] t;
	logic sel;
	logic [LEN_BITS+7:0] wide;
	logic [31:0] olen_ext;

	always_comb begin
		n_phase = phase_q;
		n_prefix = prefix_q;
		n_type = type_q;
		n_seq = seq_q;
		n_rem = rem_q;
		n_pos = pos_q;
		n_open = open_q;
		n_oseq = oseq_q;
		n_olen = olen_q;
		n_halted = halted_q;
		req_valid = 1'b0;
		req = '0;
		hdr = 1'b0;
		begin_c = 1'b0;
		vl = 1'b0;
		blen = '0;
		t = stream_byte[7:4];
		sel = SEL_VIDEO;
		wide = '0;
		olen_ext = '0;
		if (in_fire && !halted_q) begin
			unique case (phase_q)
				PH_WAIT: begin
					n_prefix = 1'b0;
					if (stream_byte == PREFIX_BYTE) begin
						n_prefix = 1'b1;
						n_phase = PH_HEADER;
					end else begin
						hdr = 1'b1;
					end
				end
				PH_HEADER: hdr = 1'b1;
				PH_EXPLEN: begin
					begin_c = 1'b1;
					blen = stream_byte;
				end
				PH_VARLEN_FIRST: begin
					vl = 1'b1;
					wide = (LEN_BITS+8)'(stream_byte);
				end
				PH_VARLEN_MORE: begin
					vl = 1'b1;
					if (rem_q >= LEN_BITS'(128)) begin
						wide = {rem_q - LEN_BITS'(128), 7'b0} + (LEN_BITS+8)'(stream_byte);
					end else begin
						wide = (LEN_BITS+8)'(stream_byte);
					end
					if (rem_q == LEN_MAX) wide = (LEN_BITS+8)'(LEN_MAX);
				end
				PH_SKIP: begin
					if (rem_q != '0) n_rem = rem_q - 1'b1;
					if (n_rem == '0) n_phase = PH_WAIT;
				end
				PH_PAYLOAD: begin
					sel = (type_q >= 3'd3) ? SEL_AUDIO : SEL_VIDEO;
					if (olen_q[sel] != LEN_MAX) n_olen[sel] = olen_q[sel] + 1'b1;
					if (rem_q != '0) n_rem = rem_q - 1'b1;
					if (n_rem == '0) n_phase = PH_WAIT;
					req_valid = 1'b1;
					req.kind = KIND_PAYLOAD;
					req.sel = sel;
					req.val = stream_byte;
				end
				default: n_phase = PH_WAIT;
			endcase

			if (hdr) begin
				n_seq = stream_byte[3:0];
				if (t > 4'd4) begin
					n_halted = 1'b1;
					req_valid = 1'b1;
					req.kind = KIND_ERROR;
				end else begin
					n_type = t[2:0];
					if (t == 4'd0) begin
						n_phase = PH_VARLEN_FIRST;
					end else if (n_prefix || t == 4'd2) begin
						n_phase = PH_EXPLEN;
					end else begin
						begin_c = 1'b1;
						blen = (t == 4'd1) ? LEN_VIDEO : ((t == 4'd3) ? LEN_AUDIO_A : LEN_AUDIO_B);
					end
				end
			end

			if (vl) begin
				if (wide > (LEN_BITS+8)'(LEN_MAX)) wide = (LEN_BITS+8)'(LEN_MAX);
				n_rem = wide[LEN_BITS-1:0];
				if (stream_byte[7]) n_phase = PH_VARLEN_MORE;
				else n_phase = (n_rem != '0) ? PH_SKIP : PH_WAIT;
			end

			if (begin_c) begin
				sel = (n_type >= 3'd3) ? SEL_AUDIO : SEL_VIDEO;
				if (sel == SEL_AUDIO) n_pos = pos_q + 32'(blen);
				if (open_q[sel] && oseq_q[sel] != {1'b0, n_seq}) begin
					olen_ext = 32'(olen_q[sel]);
					req_valid = 1'b1;
					req.kind = KIND_CLOSE;
					req.sel = sel;
					req.seq = oseq_q[sel][3:0];
					req.size = (|olen_ext[31:SIZE_BITS]) ? '1 : olen_ext[SIZE_BITS-1:0];
					req.need_ts = (sel == SEL_VIDEO);
					req.pos = n_pos;
					n_open[sel] = 1'b0;
				end
				if (!n_open[sel]) begin
					n_open[sel] = 1'b1;
					n_oseq[sel] = {1'b0, n_seq};
					n_olen[sel] = '0;
				end
				if (n_type == 3'd2) n_oseq[sel] = n_oseq[sel] - 1'b1;
				n_rem = LEN_BITS'(blen);
				n_phase = (blen != '0) ? PH_PAYLOAD : PH_WAIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT;
			prefix_q <= 1'b0;
			type_q <= '0;
			seq_q <= '0;
			rem_q <= '0;
			pos_q <= '0;
			open_q <= '0;
			oseq_q <= '{default: '0};
			olen_q <= '{default: '0};
			halted_q <= 1'b0;
		end else begin
			phase_q <= n_phase;
			prefix_q <= n_prefix;
			type_q <= n_type;
			seq_q <= n_seq;
			rem_q <= n_rem;
			pos_q <= n_pos;
			open_q <= n_open;
			oseq_q <= n_oseq;
			olen_q <= n_olen;
			halted_q <= n_halted;
		end
	end

endmodule

// ----- src/cavd_queue.sv -----
// Two-entry request queue between the parser and the result stage.
`timescale 1ns / 1ps
module cavd_queue import cavd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input cavd_req_t wr_data,
	output logic q_full,
	input logic rd_en,
	output cavd_req_t rd_data,
	output logic q_empty
);

	cavd_req_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign q_full = (count_q == 2'd2);
	assign q_empty = (count_q == 2'd0);
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (wr_en) wr_ptr_q <= ~wr_ptr_q;
			if (rd_en) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(wr_en) - 2'(rd_en);
		end
	end

endmodule

// ----- src/cavd_back.sv -----
// Result stage: timestamp multiply, bit-serial divide and output register.
`timescale 1ns / 1ps
module cavd_back import cavd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic [15:0] bitrate,
	input logic q_empty,
	input cavd_req_t q_data,
	output logic q_pop,
	input logic pop,
	output logic empty,
	output logic [1:0] event_kind,
	output logic stream_select,
	output logic [7:0] payload_value,
	output logic [3:0] closed_sequence,
	output logic [23:0] packet_size,
	output logic [44:0] timestamp
);

	typedef enum logic [1:0] {B_IDLE, B_MUL, B_DIV, B_DONE} bstate_t;

	localparam logic [5:0] LAST_STEP = 6'(TS_BITS - 1);

	bstate_t state_q;
	logic out_valid_q;
	cavd_req_t work_q;
	logic [TS_BITS-1:0] quot_q;
	logic [15:0] rem_q;
	logic [15:0] div_q;
	logic [5:0] cnt_q;
	logic free;
	logic load;
	logic [16:0] r2;

	assign free = !out_valid_q || pop;
	assign empty = !out_valid_q;
	assign q_pop = (state_q == B_IDLE) && !q_empty && (q_data.need_ts || free);
	assign load = ((state_q == B_IDLE) && q_pop && !q_data.need_ts) ||
		((state_q == B_DONE) && free);
	assign r2 = {rem_q, quot_q[TS_BITS-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			out_valid_q <= 1'b0;
			cnt_q <= '0;
			work_q <= '0;
			quot_q <= '0;
			rem_q <= '0;
			div_q <= '0;
			event_kind <= '0;
			stream_select <= 1'b0;
			payload_value <= '0;
			closed_sequence <= '0;
			packet_size <= '0;
			timestamp <= '0;
		end else begin
			if (load) out_valid_q <= 1'b1;
			else if (pop) out_valid_q <= 1'b0;
			unique case (state_q)
				B_IDLE: begin
					if (q_pop) begin
						if (q_data.need_ts) begin
							work_q <= q_data;
							state_q <= B_MUL;
						end else begin
							event_kind <= q_data.kind;
							stream_select <= q_data.sel;
							payload_value <= q_data.val;
							closed_sequence <= q_data.seq;
							packet_size <= q_data.size;
							timestamp <= '0;
						end
					end
				end
				B_MUL: begin
					quot_q <= TS_BITS'(work_q.pos) * TS_BITS'(TS_SCALE);
					rem_q <= '0;
					div_q <= (bitrate == '0) ? 16'd1 : bitrate;
					cnt_q <= '0;
					state_q <= B_DIV;
				end
				B_DIV: begin
					// Restoring division, one quotient bit per cycle.
					if (r2 >= {1'b0, div_q}) begin
						rem_q <= 16'(r2 - {1'b0, div_q});
						quot_q <= {quot_q[TS_BITS-2:0], 1'b1};
					end else begin
						rem_q <= r2[15:0];
						quot_q <= {quot_q[TS_BITS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST_STEP) state_q <= B_DONE;
				end
				B_DONE: begin
					if (free) begin
						event_kind <= work_q.kind;
						stream_select <= work_q.sel;
						payload_value <= work_q.val;
						closed_sequence <= work_q.seq;
						packet_size <= work_q.size;
						timestamp <= quot_q;
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

// ----- src/chunked_av_stream_deframer.sv -----
// Top level of the chunked audio/video stream deframer.
//
// Usage: raw container bytes enter through push/full, one byte per request;
// a byte is taken at a clock edge with push high and full low. Results leave
// through empty/pop: the oldest result sits on the ports while empty is low
// and is taken at an edge with pop high and empty low. The bitrate register
// is written with audio_bitrate_we and audio_bitrate_wdata; the user must
// write it only while idle; the block does not enforce this. A payload byte
// or audio close passes through the request queue and the output register;
// a video close is multiplied, then divided one quotient bit per cycle.
// Throughput: one byte per cycle while full is low, set by the parser;
// while a video close is being divided, the two-entry request queue fills
// and full rises until the divider finishes. A stalled receiver holds the
// output register, the queue fills behind it and full then holds off the
// sender. Reset clears all parser state, both open packets, the queue and
// the output register, and loads the bitrate with 6400.
`timescale 1ns / 1ps
module chunked_av_stream_deframer import cavd_pkg::*; #(
	parameter int LEN_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	input logic push,
	output logic full,
	input logic [7:0] stream_byte,
	output logic empty,
	input logic pop,
	output logic [1:0] event_kind,
	output logic stream_select,
	output logic [7:0] payload_value,
	output logic [3:0] closed_sequence,
	output logic [23:0] packet_size,
	output logic [44:0] timestamp,
	input logic audio_bitrate_we,
	input logic [15:0] audio_bitrate_wdata
);

	logic [15:0] bitrate_q;
	logic q_full, q_empty, q_pop, req_valid, in_fire;
	cavd_req_t req, q_data;

	assign full = q_full;
	assign in_fire = push && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bitrate_q <= BITRATE_RESET;
		else if (audio_bitrate_we) bitrate_q <= audio_bitrate_wdata;
	end

	cavd_front #(.LEN_BITS(LEN_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_fire(in_fire), .stream_byte(stream_byte),
		.req_valid(req_valid), .req(req)
	);

	cavd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr_en(req_valid), .wr_data(req), .q_full(q_full),
		.rd_en(q_pop), .rd_data(q_data), .q_empty(q_empty)
	);

	cavd_back u_back (
		.clk(clk), .arst_n(arst_n), .bitrate(bitrate_q), .q_empty(q_empty),
		.q_data(q_data), .q_pop(q_pop), .pop(pop), .empty(empty),
		.event_kind(event_kind), .stream_select(stream_select),
		.payload_value(payload_value), .closed_sequence(closed_sequence),
		.packet_size(packet_size), .timestamp(timestamp)
	);

endmodule

// ----- src/cavd_checker.sv -----
// Port-level checker for the deframer and its bind.
`timescale 1ns / 1ps
module cavd_props import cavd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input logic pop,
	input logic [1:0] event_kind,
	input logic stream_select,
	input logic [7:0] payload_value,
	input logic [3:0] closed_sequence,
	input logic [23:0] packet_size,
	input logic [44:0] timestamp
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(event_kind) && $stable(timestamp))
		else $error("waiting result changed");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> event_kind == KIND_PAYLOAD || event_kind == KIND_CLOSE ||
			event_kind == KIND_ERROR)
		else $error("bad event kind");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && event_kind == KIND_PAYLOAD |->
			closed_sequence == 4'd0 && packet_size == 24'd0 && timestamp == 45'd0)
		else $error("payload result carries close fields");

	a_audio_ts: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && stream_select == SEL_AUDIO |-> timestamp == 45'd0)
		else $error("audio result with timestamp");

	a_error: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && event_kind == KIND_ERROR |-> stream_select == 1'b0 && payload_value == 8'd0)
		else $error("error result with payload");

endmodule

bind chunked_av_stream_deframer cavd_props u_cavd_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop), .event_kind(event_kind),
	.stream_select(stream_select), .payload_value(payload_value),
	.closed_sequence(closed_sequence), .packet_size(packet_size), .timestamp(timestamp)
);

// ----- tb/sv/cavd_checker.sv -----
// Scoreboard for the deframer: byte-level prediction and result comparison.
`timescale 1ns / 1ps
module cavd_checker import cavd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input logic full,
	input logic [7:0] stream_byte,
	input logic empty,
	input logic pop,
	input logic [1:0] event_kind,
	input logic stream_select,
	input logic [7:0] payload_value,
	input logic [3:0] closed_sequence,
	input logic [23:0] packet_size,
	input logic [44:0] timestamp,
	input logic audio_bitrate_we,
	input logic [15:0] audio_bitrate_wdata,
	output int fail_count,
	output int pending
);

	localparam longint unsigned LEN_MAX = 64'hFF_FFFF;

	typedef enum logic [2:0] {
		P_WAIT, P_HEADER, P_EXPLEN, P_VLEN_FIRST, P_VLEN_MORE, P_SKIP, P_PAYLOAD
	} parse_t;

	typedef struct {
		logic [1:0] kind;
		logic sel;
		logic [7:0] val;
		logic [3:0] seq;
		logic [23:0] size;
		logic [44:0] ts;
	} event_t;

	event_t events_due[$];

	logic [15:0] bitrate;
	parse_t phase;
	bit prefixed;
	int unsigned ctype;
	int unsigned cseq;
	longint unsigned remain;
	logic [31:0] apos;
	bit open_pkt[2];
	int open_seq[2];
	longint unsigned open_len[2];
	bit halted;

	assign pending = events_due.size();

	task automatic add_event(logic [1:0] k, logic s, logic [7:0] v, logic [3:0] q,
			logic [23:0] sz, logic [44:0] t);
		event_t e;
		e.kind = k; e.sel = s; e.val = v; e.seq = q; e.size = sz; e.ts = t;
		events_due.push_back(e);
	endtask

	task automatic start_chunk(longint unsigned len);
		int sel;
		longint unsigned div;
		logic [44:0] t;
		sel = (ctype >= 3) ? 0 : 1;
		if (sel == 0)
			apos = apos + 32'(len);
		if (open_pkt[sel] && open_seq[sel] != int'(cseq)) begin
			t = '0;
			if (sel == 1) begin
				div = (bitrate == 0) ? 1 : longint'(bitrate);
				t = 45'((longint'(apos) * 8000) / div);
			end
			add_event(KIND_CLOSE, sel[0], 8'd0, 4'(open_seq[sel]), 24'(open_len[sel]), t);
			open_pkt[sel] = 0;
		end
		if (!open_pkt[sel]) begin
			open_pkt[sel] = 1;
			open_seq[sel] = int'(cseq);
			open_len[sel] = 0;
		end
		if (ctype == 2)
			open_seq[sel] = open_seq[sel] - 1;
		remain = len;
		phase = (len != 0) ? P_PAYLOAD : P_WAIT;
	endtask

	task automatic take_header(logic [7:0] h);
		int unsigned t;
		t = h[7:4];
		cseq = h[3:0];
		if (t > 4) begin
			halted = 1;
			add_event(KIND_ERROR, 1'b0, 8'd0, 4'd0, 24'd0, 45'd0);
		end else begin
			ctype = t;
			if (t == 0)
				phase = P_VLEN_FIRST;
			else if (prefixed || t == 2)
				phase = P_EXPLEN;
			else if (t == 1)
				start_chunk(LEN_VIDEO);
			else
				start_chunk((t == 3) ? LEN_AUDIO_A : LEN_AUDIO_B);
		end
	endtask

	task automatic end_vlen(logic [7:0] c, longint unsigned acc);
		if (acc > LEN_MAX)
			acc = LEN_MAX;
		remain = acc;
		if (c[7])
			phase = P_VLEN_MORE;
		else
			phase = (acc != 0) ? P_SKIP : P_WAIT;
	endtask

	task automatic predict_byte(logic [7:0] c);
		longint unsigned acc;
		int sel;
		if (!halted) begin
			case (phase)
				P_WAIT: begin
					prefixed = (c == PREFIX_BYTE);
					if (prefixed)
						phase = P_HEADER;
					else
						take_header(c);
				end
				P_HEADER: take_header(c);
				P_EXPLEN: start_chunk(c);
				P_VLEN_FIRST: end_vlen(c, c);
				P_VLEN_MORE: begin
					acc = (remain >= 128) ? (((remain - 128) << 7) + c) : c;
					if (remain >= LEN_MAX)
						acc = LEN_MAX;
					end_vlen(c, acc);
				end
				P_SKIP: begin
					if (remain != 0)
						remain--;
					if (remain == 0)
						phase = P_WAIT;
				end
				P_PAYLOAD: begin
					sel = (ctype >= 3) ? 0 : 1;
					if (open_len[sel] < LEN_MAX)
						open_len[sel]++;
					if (remain != 0)
						remain--;
					if (remain == 0)
						phase = P_WAIT;
					add_event(KIND_PAYLOAD, sel[0], c, 4'd0, 24'd0, 45'd0);
				end
				default: phase = P_WAIT;
			endcase
		end
	endtask

	task automatic compare_event();
		event_t e;
		if (events_due.size() == 0) begin
			$error("result with nothing expected: kind %0d", event_kind);
			fail_count++;
		end else begin
			e = events_due.pop_front();
			if (event_kind !== e.kind) begin
				$error("event_kind expected %0d got %0d", e.kind, event_kind);
				fail_count++;
			end
			if (stream_select !== e.sel) begin
				$error("stream_select expected %0d got %0d", e.sel, stream_select);
				fail_count++;
			end
			if (payload_value !== e.val) begin
				$error("payload_value expected %0d got %0d", e.val, payload_value);
				fail_count++;
			end
			if (closed_sequence !== e.seq) begin
				$error("closed_sequence expected %0d got %0d", e.seq, closed_sequence);
				fail_count++;
			end
			if (packet_size !== e.size) begin
				$error("packet_size expected %0d got %0d", e.size, packet_size);
				fail_count++;
			end
			if (timestamp !== e.ts) begin
				$error("timestamp expected %0d got %0d", e.ts, timestamp);
				fail_count++;
			end
		end
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bitrate = BITRATE_RESET;
			phase = P_WAIT;
			prefixed = 0;
			ctype = 0;
			cseq = 0;
			remain = 0;
			apos = '0;
			open_pkt = '{0, 0};
			open_seq = '{0, 0};
			open_len = '{0, 0};
			halted = 0;
			events_due.delete();
		end else begin
			if (audio_bitrate_we)
				bitrate = audio_bitrate_wdata;
			if (pop && !empty)
				compare_event();
			if (push && !full)
				predict_byte(stream_byte);
		end
	end

endmodule

// ----- tb/sv/testbench.sv -----
// Top of the deframer testbench: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
	import cavd_pkg::*;

	localparam int CYCLE_LIMIT = 600000;

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	logic [7:0] stream_byte = '0;
	logic pop = 0;
	logic audio_bitrate_we = 0;
	logic [15:0] audio_bitrate_wdata = '0;
	logic full, empty, stream_select;
	logic [1:0] event_kind;
	logic [7:0] payload_value;
	logic [3:0] closed_sequence;
	logic [23:0] packet_size;
	logic [44:0] timestamp;
	int fail_count, pending;
	int tx_idle = 0, rx_idle = 0;
	int bytes_sent = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	chunked_av_stream_deframer u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .stream_byte(stream_byte),
		.empty(empty), .pop(pop), .event_kind(event_kind), .stream_select(stream_select),
		.payload_value(payload_value), .closed_sequence(closed_sequence),
		.packet_size(packet_size), .timestamp(timestamp),
		.audio_bitrate_we(audio_bitrate_we), .audio_bitrate_wdata(audio_bitrate_wdata)
	);

	cavd_checker u_checker (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .stream_byte(stream_byte),
		.empty(empty), .pop(pop), .event_kind(event_kind), .stream_select(stream_select),
		.payload_value(payload_value), .closed_sequence(closed_sequence),
		.packet_size(packet_size), .timestamp(timestamp),
		.audio_bitrate_we(audio_bitrate_we), .audio_bitrate_wdata(audio_bitrate_wdata),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		pop <= ($urandom_range(0, 99) >= rx_idle);
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic send_byte(logic [7:0] b);
		if ($urandom_range(0, 99) < tx_idle) begin
			push <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1;
		stream_byte <= b;
		do @(posedge clk); while (full);
		bytes_sent++;
	endtask

	// The last accepted byte may still be in flight through the divider.
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_bitrate(logic [15:0] v);
		audio_bitrate_we <= 1;
		audio_bitrate_wdata <= v;
		@(posedge clk);
		audio_bitrate_we <= 0;
	endtask

	task automatic send_payload(int n);
		repeat (n) send_byte(8'($urandom()));
	endtask

	// One well-formed chunk with random type, sequence and content.
	task automatic send_chunk();
		int r, len, hi;
		logic [3:0] sq;
		r = $urandom_range(0, 99);
		sq = ($urandom_range(0, 3) == 0) ? 4'($urandom()) : 4'($urandom_range(0, 2));
		if (r < 10) begin
			// A header record: its body is skipped by the parser.
			send_byte({4'd0, sq});
			if ($urandom_range(0, 3) == 0) begin
				hi = $urandom_range(0, 1);
				len = $urandom_range(0, 20);
				send_byte(8'h80 | 8'(hi));
				send_byte(8'(len));
				len = hi * 128 + len;
			end else begin
				len = $urandom_range(0, 6);
				send_byte(8'(len));
			end
			send_payload(len);
		end else if (r < 18) begin
			send_byte({4'd1, sq});
			send_payload(LEN_VIDEO);
		end else if (r < 35) begin
			send_byte({4'd2, sq});
			len = $urandom_range(0, 10);
			send_byte(8'(len));
			send_payload(len);
		end else if (r < 50) begin
			send_byte({4'd3, sq});
			send_payload(LEN_AUDIO_A);
		end else if (r < 65) begin
			send_byte({4'd4, sq});
			send_payload(LEN_AUDIO_B);
		end else begin
			send_byte(PREFIX_BYTE);
			send_byte({4'($urandom_range(1, 4)), sq});
			len = ($urandom_range(0, 19) == 0) ? 255 : $urandom_range(0, 12);
			send_byte(8'(len));
			send_payload(len);
		end
	endtask

	task automatic random_phase(int target);
		while (bytes_sent < target) send_chunk();
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Prefixed audio with extreme payload bytes, zero-length video,
		// type 2 chunk, two empty header records, then sequence changes on both streams.
		send_byte(PREFIX_BYTE); send_byte(8'h31); send_byte(8'd2);
		send_byte(8'h00); send_byte(8'hFF);
		send_byte(PREFIX_BYTE); send_byte(8'h15); send_byte(8'd0);
		send_byte(8'h25); send_byte(8'd1); send_byte(8'hA5);
		send_byte(8'h00); send_byte(8'h00);
		send_byte(8'h0F); send_byte(8'h80); send_byte(8'h00);
		send_byte(PREFIX_BYTE); send_byte(8'h1F); send_byte(8'd1); send_byte(8'h5A);
		send_byte(PREFIX_BYTE); send_byte(8'h32); send_byte(8'd0);
		drain();

		set_bitrate(16'd1);
		tx_idle = 32; rx_idle = 58;
		random_phase(380);
		drain();

		set_bitrate(16'hFFFF);
		tx_idle = 58; rx_idle = 32;
		random_phase(760);
		drain();

		set_bitrate(16'($urandom_range(1, 65535)));
		tx_idle = 0; rx_idle = 0;
		random_phase(1100);

		// A doubled prefix reads as an unknown type; the block then halts.
		send_byte(PREFIX_BYTE);
		send_byte(PREFIX_BYTE);
		repeat (8) send_byte(8'($urandom()));
		drain();

		if (fail_count == 0 && pending == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- filelist.f -----
src/cavd_pkg.sv
src/cavd_front.sv
src/cavd_queue.sv
src/cavd_back.sv
src/chunked_av_stream_deframer.sv
src/cavd_checker.sv
tb/sv/cavd_checker.sv
tb/sv/testbench.sv
